>>> rtl/core/pve_pkg.sv
package pve_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned MAX_EXTRA = 8;
    localparam int unsigned EXTRA_W  = 4;
    localparam logic [BYTE_W-1:0] ALL_ONES_BYTE = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0]  first_byte;
        logic [EXTRA_W-1:0] n_extra;
        logic [VALUE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
    } t_back_stat;

endpackage

>>> rtl/core/pve_ifs.sv
interface pve_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface pve_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/core/pve_front.sv
module pve_front (
    pve_in_if.sink          i_in,
    input  pve_pkg::t_q_stat i_q_stat,
    output pve_pkg::t_push   o_push
);
    import pve_pkg::*;

    logic [EXTRA_W-1:0] w_extra;
    logic [BYTE_W-1:0]  w_prefix;
    logic [BYTE_W-1:0]  w_high;
    logic [BYTE_W-1:0]  w_first;

    // extra byte count from the group thresholds 2^7 .. 2^56
    always_comb begin
        int j;
        w_extra = '0;
        for (j = 1; j <= int'(MAX_EXTRA); j++) begin
            if ((i_in.value >> (GROUP_W * j)) != '0) begin
                w_extra = EXTRA_W'(j);
            end
        end
    end

    always_comb begin
        w_prefix = BYTE_W'(ALL_ONES_BYTE << (EXTRA_W'(MAX_EXTRA) - w_extra));
        w_high   = i_in.value[{w_extra[2:0], 3'b000} +: BYTE_W];
        if (w_extra == EXTRA_W'(MAX_EXTRA)) begin
            w_first = ALL_ONES_BYTE;
        end else begin
            w_first = w_prefix | w_high;
        end
    end

    assign i_in.ready              = !i_q_stat.full;
    assign o_push.valid            = i_in.valid && !i_q_stat.full;
    assign o_push.entry.first_byte = w_first;
    assign o_push.entry.n_extra    = w_extra;
    assign o_push.entry.value      = i_in.value;

endmodule

>>> rtl/core/pve_queue.sv
module pve_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pve_pkg::t_push   i_push,
    input  logic             i_pop,
    output pve_pkg::t_entry  o_head,
    output pve_pkg::t_q_stat o_stat
);
    import pve_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign w_do_push = i_push.valid && (r_count != CNT_W'(DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

>>> rtl/core/pve_back.sv
module pve_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pve_pkg::t_entry     i_head,
    input  pve_pkg::t_q_stat    i_q_stat,
    output logic                o_pop,
    output pve_pkg::t_back_stat o_stat,
    pve_out_if.source           o_out
);
    import pve_pkg::*;

    logic                r_valid, n_valid;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_last, n_last;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [EXTRA_W-1:0]  r_cnt, n_cnt;
    logic                w_advance;
    logic [2:0]          w_idx;

    assign w_advance = !r_valid || o_out.ready;
    assign w_idx     = 3'(r_cnt - EXTRA_W'(1));
    assign o_pop     = w_advance && (r_cnt == '0) && !i_q_stat.empty;

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_val   = r_val;
        n_cnt   = r_cnt;
        if (w_advance) begin
            if (r_cnt != '0) begin
                n_valid = 1'b1;
                n_byte  = r_val[{w_idx, 3'b000} +: BYTE_W];
                n_last  = (r_cnt == EXTRA_W'(1));
                n_cnt   = r_cnt - EXTRA_W'(1);
            end else if (!i_q_stat.empty) begin
                n_valid = 1'b1;
                n_byte  = i_head.first_byte;
                n_last  = (i_head.n_extra == '0);
                n_val   = i_head.value;
                n_cnt   = i_head.n_extra;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_val  <= n_val;
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;
    assign o_stat.busy    = (r_cnt != '0);

endmodule

>>> rtl/core/prefix_varint_encoder_top.sv
// path when idle: an accepted value is written into the queue, then its first byte into the back end's output register
// a value yields 1 + e output bytes, e = 0..8 extra bytes
// values below 128 need a single byte, so they stream back to back
// the back end emits one byte per cycle while o_out.ready is high; the queue takes new values while bytes drain
// reset: synchronous active-low i_rst_n empties the queue and drops any byte in flight
module prefix_varint_encoder_top #(
    parameter int unsigned QDEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pve_in_if.sink     i_in,
    pve_out_if.source  o_out
);
    import pve_pkg::*;

    t_push      w_push;
    t_q_stat    w_q_stat;
    t_entry     w_head;
    logic       w_pop;
    t_back_stat w_back_stat;

    pve_front u_front (
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push)
    );

    pve_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    pve_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_stat   (w_back_stat),
        .o_out    (o_out)
    );

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue full and empty at once");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !w_q_stat.empty)
        else $error("accepted transaction missing from queue");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> !w_back_stat.busy)
        else $error("last byte shown with bytes still pending");

    a_no_pop_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_stat.busy |-> !w_pop)
        else $error("queue popped during a run");

endmodule
